// ===== sv/ipr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and window helpers for the indicator pattern and relay pulse block.
package ipr_pkg;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_SET   = 2'd1,
        MODE_PULSE = 2'd2,
        MODE_OFF   = 2'd3
    } t_mode;

    localparam logic [2:0] PAT_OFF       = 3'd0;
    localparam logic [2:0] PAT_HEARTBEAT = 3'd1;
    localparam logic [2:0] PAT_WATCH     = 3'd2;
    localparam logic [2:0] PAT_WARNING   = 3'd3;
    localparam logic [2:0] PAT_STORM     = 3'd4;

    // Every pattern period divides this, so the clock is tracked modulo it.
    localparam int RES_MOD = 10000;
    localparam int RES_W   = $clog2(RES_MOD);
    localparam int MIN_PERIOD = 200;
    localparam int MAX_SLOTS  = RES_MOD / MIN_PERIOD;
    localparam longint unsigned CLK_SPAN = 64'd1 << 32;
    // Residue correction applied when the 32-bit clock wraps.
    localparam int RES_WRAP = int'(longint'(RES_MOD) - longint'(CLK_SPAN % RES_MOD));
    // Largest sum of residue and elapsed time is below 8 * RES_MOD.
    localparam int SUM_W = 17;
    localparam int RED_STEPS = 7;

    typedef struct packed {
        logic green;
        logic red;
        logic buzzer;
    } t_drive;

    // Reduce a value below (RED_STEPS + 1) * RES_MOD to its residue.
    function automatic logic [RES_W-1:0] ipr_reduce(input logic [SUM_W-1:0] v);
        logic [SUM_W-1:0] res;
        res = v;
        for (int k = 1; k <= RED_STEPS; k++) begin
            if (v >= SUM_W'(k * RES_MOD)) begin
                res = v - SUM_W'(k * RES_MOD);
            end
        end
        return res[RES_W-1:0];
    endfunction

    // True when (r mod period) lies in [lo, hi); period divides RES_MOD.
    function automatic logic ipr_window(input logic [RES_W-1:0] r, input int period,
                                        input int lo, input int hi);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < MAX_SLOTS; k++) begin
            if (k * period < RES_MOD) begin
                if (r >= RES_W'(k * period + lo) && r < RES_W'(k * period + hi)) begin
                    hit = 1'b1;
                end
            end
        end
        return hit;
    endfunction

endpackage

// ===== sv/ipr_pattern.sv =====
`timescale 1ns / 1ps
// Pattern decoder: LED and buzzer levels from the selected pattern and clock residue.
module ipr_pattern
    import ipr_pkg::*;
(
    input  logic [2:0]       i_pattern,
    input  logic [RES_W-1:0] i_residue,
    output t_drive           o_drive
);

    logic w_hb;
    logic w_watch;
    logic w_watch_buz;
    logic w_warn_red;
    logic w_warn_buz;
    logic w_storm;

    assign w_hb        = ipr_window(i_residue, 5000, 0, 50);
    assign w_watch     = ipr_window(i_residue, 1000, 0, 500);
    assign w_watch_buz = ipr_window(i_residue, 10000, 0, 50);
    assign w_warn_red  = ipr_window(i_residue, 400, 0, 200);
    // Two short chirps per warning period
    assign w_warn_buz  = ipr_window(i_residue, 2000, 0, 60)
                       | ipr_window(i_residue, 2000, 120, 180);
    assign w_storm     = ipr_window(i_residue, 200, 0, 100);

    always_comb begin
        o_drive = '0;
        case (i_pattern)
            PAT_HEARTBEAT: begin
                o_drive.green = w_hb;
            end
            PAT_WATCH: begin
                o_drive.green  = w_watch;
                o_drive.red    = w_watch;
                o_drive.buzzer = w_watch_buz;
            end
            PAT_WARNING: begin
                o_drive.red    = w_warn_red;
                o_drive.buzzer = w_warn_buz;
            end
            PAT_STORM: begin
                o_drive.red    = w_storm;
                o_drive.buzzer = w_storm;
            end
            default: begin
                o_drive = '0;
            end
        endcase
    end

endmodule

// ===== sv/indicator_pattern_and_relay_pulse.sv =====
`timescale 1ns / 1ps
// Top level: command register, state update and result register.
// A transfer accepted into the command register moves on to the result register when the result side can take it.
// Throughput: one item per cycle while the result side takes each transfer.
// The clock is tracked as a residue modulo the common pattern period, so one pass suffices.
// Reset (synchronous, active low) empties both registers, turns everything off,
//   selects pattern off and loads the relay limit with 60000.
module indicator_pattern_and_relay_pulse
    import ipr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_elapsed_ms,
    input  logic [2:0]  i_pattern_code,
    input  logic [23:0] i_pulse_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_green_on,
    output logic        o_red_on,
    output logic        o_buzzer_on,
    output logic        o_relay_on,
    output logic [2:0]  o_active_pattern,
    output logic        o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [23:0] i_cfg_data
);

    localparam logic [23:0] RELAY_MAX_RESET = 24'd60000;

    logic [23:0]      r_relay_max;
    logic             r_in_valid;
    t_mode            r_in_mode;
    logic [15:0]      r_in_elapsed;
    logic [2:0]       r_in_code;
    logic [23:0]      r_in_pulse;
    logic             r_out_valid;
    logic             r_status;
    logic [2:0]       r_pattern;
    logic [31:0]      r_clk_ms;
    logic [RES_W-1:0] r_res;
    logic [23:0]      r_relay_rem;
    logic             r_relay_on;
    t_drive           r_drive;

    logic             n_status;
    logic [2:0]       n_pattern;
    logic [31:0]      n_clk_ms;
    logic [RES_W-1:0] n_res;
    logic [23:0]      n_relay_rem;
    logic             n_relay_on;
    t_drive           n_drive;

    logic             w_advance;
    logic [32:0]      w_clk_sum;
    logic [RES_W-1:0] w_res_add;
    logic [RES_W:0]   w_res_fix;
    logic [RES_W-1:0] w_res_tick;
    t_drive           w_tick_drive;

    assign w_advance   = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready     = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;

    // Advance the clock and its residue; correct the residue on a 32-bit wrap
    assign w_clk_sum = {1'b0, r_clk_ms} + {17'd0, r_in_elapsed};
    assign w_res_add = ipr_reduce(SUM_W'(r_res) + SUM_W'(r_in_elapsed));
    always_comb begin
        w_res_fix  = {1'b0, w_res_add} + (RES_W + 1)'(RES_WRAP);
        w_res_tick = w_res_add;
        if (w_clk_sum[32]) begin
            if (w_res_fix >= (RES_W + 1)'(RES_MOD)) begin
                w_res_tick = RES_W'(w_res_fix - (RES_W + 1)'(RES_MOD));
            end else begin
                w_res_tick = w_res_fix[RES_W-1:0];
            end
        end
    end

    ipr_pattern u_pattern (
        .i_pattern (r_pattern),
        .i_residue (w_res_tick),
        .o_drive   (w_tick_drive)
    );

    always_comb begin
        n_status    = 1'b0;
        n_pattern   = r_pattern;
        n_clk_ms    = r_clk_ms;
        n_res       = r_res;
        n_relay_rem = r_relay_rem;
        n_relay_on  = r_relay_on;
        n_drive     = r_drive;
        case (r_in_mode)
            MODE_TICK: begin
                if (r_relay_on) begin
                    if ({8'd0, r_in_elapsed} >= r_relay_rem) begin
                        n_relay_on  = 1'b0;
                        n_relay_rem = '0;
                    end else begin
                        n_relay_rem = r_relay_rem - {8'd0, r_in_elapsed};
                    end
                end
                n_clk_ms = w_clk_sum[31:0];
                n_res    = w_res_tick;
                n_drive  = w_tick_drive;
            end
            MODE_SET: begin
                if (r_in_code > PAT_STORM) begin
                    n_status = 1'b1;
                end else begin
                    n_pattern = r_in_code;
                    n_clk_ms  = '0;
                    n_res     = '0;
                    if (r_in_code == PAT_OFF) begin
                        n_drive     = '0;
                        n_relay_on  = 1'b0;
                        n_relay_rem = '0;
                    end
                end
            end
            MODE_PULSE: begin
                if (r_in_pulse == '0) begin
                    n_relay_on  = 1'b0;
                    n_relay_rem = '0;
                end else begin
                    n_relay_on  = 1'b1;
                    n_relay_rem = (r_in_pulse > r_relay_max) ? r_relay_max : r_in_pulse;
                end
            end
            MODE_OFF: begin
                n_drive     = '0;
                n_relay_on  = 1'b0;
                n_relay_rem = '0;
                n_pattern   = PAT_OFF;
                n_clk_ms    = '0;
                n_res       = '0;
            end
            default: begin
                n_status = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relay_max <= RELAY_MAX_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_status    <= 1'b0;
            r_pattern   <= PAT_OFF;
            r_clk_ms    <= '0;
            r_res       <= '0;
            r_relay_rem <= '0;
            r_relay_on  <= 1'b0;
            r_drive     <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_relay_max <= i_cfg_data;
            end
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_status    <= n_status;
                r_pattern   <= n_pattern;
                r_clk_ms    <= n_clk_ms;
                r_res       <= n_res;
                r_relay_rem <= n_relay_rem;
                r_relay_on  <= n_relay_on;
                r_drive     <= n_drive;
            end else if (i_ready) begin
                // drop the delivered result
                r_out_valid <= 1'b0;
            end
        end
    end

    // Command payload: hold while the input register waits
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_mode    <= t_mode'(i_mode);
            r_in_elapsed <= i_elapsed_ms;
            r_in_code    <= i_pattern_code;
            r_in_pulse   <= i_pulse_ms;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_green_on       = r_drive.green;
    assign o_red_on         = r_drive.red;
    assign o_buzzer_on      = r_drive.buzzer;
    assign o_relay_on       = r_relay_on;
    assign o_active_pattern = r_pattern;
    assign o_status         = r_status;

endmodule

// ===== sv/ipr_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the indicator pattern and relay pulse block, with its bind.
module ipr_checker
    import ipr_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_ready,
    input logic       o_valid,
    input logic       o_green_on,
    input logic       o_red_on,
    input logic       o_buzzer_on,
    input logic       o_relay_on,
    input logic [2:0] o_active_pattern,
    input logic       o_status
);

    // Reset empties the result side
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Pattern off always leaves the LEDs and buzzer dark
    a_off_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_active_pattern == PAT_OFF) |-> (!o_green_on && !o_red_on && !o_buzzer_on))
        else $error("indicator lit with pattern off");

    // A stalled result transfer holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_green_on) && $stable(o_red_on)
            && $stable(o_buzzer_on) && $stable(o_relay_on)
            && $stable(o_active_pattern) && $stable(o_status)))
        else $error("stalled result changed");

    // A rejected code never leaves an invalid pattern selected
    a_reject_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_active_pattern == PAT_OFF
            || o_active_pattern == PAT_HEARTBEAT || o_active_pattern == PAT_WATCH
            || o_active_pattern == PAT_WARNING || o_active_pattern == PAT_STORM))
        else $error("invalid pattern after rejected code");

endmodule

bind indicator_pattern_and_relay_pulse ipr_checker u_ipr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_ready          (i_ready),
    .o_valid          (o_valid),
    .o_green_on       (o_green_on),
    .o_red_on         (o_red_on),
    .o_buzzer_on      (o_buzzer_on),
    .o_relay_on       (o_relay_on),
    .o_active_pattern (o_active_pattern),
    .o_status         (o_status)
);

// ===== bench/indicator_pattern_and_relay_pulse_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the indicator pattern and relay pulse block: directed table, random phases.
module indicator_pattern_and_relay_pulse_tb;
    import ipr_pkg::*;

    localparam int HALF_PERIOD     = 2;
    localparam int RESET_CYCLES    = 6;
    localparam int SETTLE_CYCLES   = 6;
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_CYCLES     = 300;
    localparam int PHASE_ITEMS     = 300;
    localparam int FULL_RATE_ITEMS = 200;
    localparam int IDLE_PCT        = 32;

    localparam logic STATUS_GOOD     = 1'b0;
    localparam logic STATUS_BAD_CODE = 1'b1;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] elapsed;
        logic [2:0]  code;
        logic [23:0] pulse;
    } t_lamp_cmd;

    typedef struct packed {
        logic       green;
        logic       red;
        logic       buzzer;
        logic       relay;
        logic [2:0] pattern;
        logic       status;
    } t_lamp_levels;

    typedef struct packed {
        t_lamp_cmd    cmd;
        logic         typed;
        t_lamp_levels want;
    } t_lamp_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_mode = MODE_TICK;
    logic [15:0] i_elapsed_ms = '0;
    logic [2:0]  i_pattern_code = '0;
    logic [23:0] i_pulse_ms = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_green_on;
    logic        o_red_on;
    logic        o_buzzer_on;
    logic        o_relay_on;
    logic [2:0]  o_active_pattern;
    logic        o_status;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [23:0] i_cfg_data = '0;

    indicator_pattern_and_relay_pulse i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_mode           (i_mode),
        .i_elapsed_ms     (i_elapsed_ms),
        .i_pattern_code   (i_pattern_code),
        .i_pulse_ms       (i_pulse_ms),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_green_on       (o_green_on),
        .o_red_on         (o_red_on),
        .o_buzzer_on      (o_buzzer_on),
        .o_relay_on       (o_relay_on),
        .o_active_pattern (o_active_pattern),
        .o_status         (o_status),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Predicted state of the block
    logic [23:0] relay_limit = 24'd60000;
    logic [2:0]  lamp_pattern = PAT_OFF;
    logic [31:0] lamp_clock = '0;
    logic [23:0] relay_left = '0;
    logic        relay_live = 1'b0;
    logic        green_lvl = 1'b0;
    logic        red_lvl = 1'b0;
    logic        buzz_lvl = 1'b0;

    t_lamp_levels lamp_expect[$];
    t_lamp_row    lamp_rows[$];
    int           mismatches = 0;
    int           valid_idle_pct = IDLE_PCT;
    int           ready_idle_pct = IDLE_PCT;
    int           hold_asks = 0;
    int           holds_done = 0;
    int unsigned  hold_left = 0;
    int unsigned  stall_cycles = 0;

    function automatic t_lamp_cmd cmd(t_mode m, int unsigned el, int unsigned code,
                                      int unsigned pulse);
        t_lamp_cmd c;
        c.mode = m;
        c.elapsed = 16'(el);
        c.code = 3'(code);
        c.pulse = 24'(pulse);
        return c;
    endfunction

    function automatic t_lamp_levels lv(int unsigned g, int unsigned r, int unsigned b,
                                        int unsigned relay, logic [2:0] pat, logic st);
        t_lamp_levels l;
        l.green = 1'(g);
        l.red = 1'(r);
        l.buzzer = 1'(b);
        l.relay = 1'(relay);
        l.pattern = pat;
        l.status = st;
        return l;
    endfunction

    function automatic void lamps_all_off();
        green_lvl = 1'b0;
        red_lvl = 1'b0;
        buzz_lvl = 1'b0;
        relay_live = 1'b0;
        relay_left = '0;
        lamp_pattern = PAT_OFF;
        lamp_clock = '0;
    endfunction

    // Advance the predicted state by one command and return the levels it leaves.
    function automatic t_lamp_levels step_lamps(t_lamp_cmd c);
        t_lamp_levels r;
        logic [31:0]  s;
        r.status = STATUS_GOOD;
        case (c.mode)
            MODE_TICK: begin
                if (relay_live) begin
                    if (c.elapsed >= relay_left) begin
                        relay_live = 1'b0;
                        relay_left = '0;
                    end else begin
                        relay_left = relay_left - c.elapsed;
                    end
                end
                lamp_clock = lamp_clock + {16'd0, c.elapsed};
                green_lvl = 1'b0;
                red_lvl = 1'b0;
                buzz_lvl = 1'b0;
                case (lamp_pattern)
                    PAT_HEARTBEAT: begin
                        green_lvl = (lamp_clock % 5000) < 50;
                    end
                    PAT_WATCH: begin
                        green_lvl = (lamp_clock % 1000) < 500;
                        red_lvl = green_lvl;
                        buzz_lvl = (lamp_clock % 10000) < 50;
                    end
                    PAT_WARNING: begin
                        red_lvl = (lamp_clock % 400) < 200;
                        s = lamp_clock % 2000;
                        buzz_lvl = (s < 60) || (s >= 120 && s < 180);
                    end
                    PAT_STORM: begin
                        red_lvl = (lamp_clock % 200) < 100;
                        buzz_lvl = red_lvl;
                    end
                    default: ;
                endcase
            end
            MODE_SET: begin
                if (c.code > PAT_STORM) begin
                    r.status = STATUS_BAD_CODE;
                end else begin
                    lamp_pattern = c.code;
                    lamp_clock = '0;
                    if (c.code == PAT_OFF) lamps_all_off();
                end
            end
            MODE_PULSE: begin
                if (c.pulse == '0) begin
                    relay_live = 1'b0;
                    relay_left = '0;
                end else begin
                    relay_left = (c.pulse > relay_limit) ? relay_limit : c.pulse;
                    relay_live = 1'b1;
                end
            end
            default: lamps_all_off();
        endcase
        r.green = green_lvl;
        r.red = red_lvl;
        r.buzzer = buzz_lvl;
        r.relay = relay_live;
        r.pattern = lamp_pattern;
        return r;
    endfunction

    function automatic t_lamp_cmd random_cmd();
        t_lamp_cmd   c;
        int unsigned pick;
        c = cmd(MODE_TICK, $urandom, $urandom, $urandom);
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            case ($urandom_range(0, 3))
                0: c.elapsed = 16'($urandom_range(0, 60));
                1: c.elapsed = 16'($urandom_range(0, 1200));
                2: c.elapsed = 16'($urandom_range(0, 10000));
                default: ;
            endcase
        end else if (pick < 75) begin
            c.mode = MODE_SET;
            if ($urandom_range(0, 4) != 0) c.code = 3'($urandom_range(1, 4));
        end else if (pick < 95) begin
            c.mode = MODE_PULSE;
            case ($urandom_range(0, 4))
                0: c.pulse = '0;
                1: c.pulse = 24'($urandom_range(1, 2000));
                2: c.pulse = relay_limit + 24'($urandom_range(0, 2)) - 24'd1;
                3: c.pulse = 24'($urandom_range(1, 100000));
                default: ;
            endcase
        end else begin
            c.mode = MODE_OFF;
        end
        return c;
    endfunction

    task automatic offer_cmd(t_lamp_cmd c, logic typed, t_lamp_levels want);
        t_lamp_levels predicted;
        while ($urandom_range(0, 99) < valid_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= c.mode;
        i_elapsed_ms <= c.elapsed;
        i_pattern_code <= c.code;
        i_pulse_ms <= c.pulse;
        do @(posedge i_clk); while (!o_ready);
        predicted = step_lamps(c);
        lamp_expect.push_back(typed ? want : predicted);
    endtask

    // Drop valid and wait until every result is back and the pipeline is quiet.
    task automatic settle();
        i_valid <= 1'b0;
        while (lamp_expect.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [23:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        relay_limit = v;
    endtask

    function automatic void check_field(string name, logic [2:0] want, logic [2:0] seen);
        if (seen !== want) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_lamp_levels want;
        if (i_rst_n && o_valid && i_ready) begin
            if (lamp_expect.size() == 0) begin
                $error("result transfer with nothing outstanding");
                mismatches++;
            end else begin
                want = lamp_expect.pop_front();
                check_field("green_on", want.green, o_green_on);
                check_field("red_on", want.red, o_red_on);
                check_field("buzzer_on", want.buzzer, o_buzzer_on);
                check_field("relay_on", want.relay, o_relay_on);
                check_field("active_pattern", want.pattern, o_active_pattern);
                check_field("status", want.status, o_status);
            end
        end
    end

    // Result side: random back-pressure, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (holds_done != hold_asks) begin
            holds_done <= hold_asks;
            hold_left <= HOLD_CYCLES;
            i_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= ready_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [23:0] limits[5];
        t_lamp_row   row;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table; typed rows carry their expected levels
        lamp_rows.push_back({cmd(MODE_TICK, 0, 0, 0), 1'b1,
                             lv(0, 0, 0, 0, PAT_OFF, STATUS_GOOD)});
        lamp_rows.push_back({cmd(MODE_SET, 0, 7, 0), 1'b1,
                             lv(0, 0, 0, 0, PAT_OFF, STATUS_BAD_CODE)});
        lamp_rows.push_back({cmd(MODE_PULSE, 0, 0, 0), 1'b1,
                             lv(0, 0, 0, 0, PAT_OFF, STATUS_GOOD)});
        // oversized pulse clamps to the reset limit, then counts down to exactly zero
        lamp_rows.push_back({cmd(MODE_PULSE, 65535, 7, 24'hFFFFFF), 1'b1,
                             lv(0, 0, 0, 1, PAT_OFF, STATUS_GOOD)});
        lamp_rows.push_back({cmd(MODE_TICK, 59999, 0, 0), 1'b1,
                             lv(0, 0, 0, 1, PAT_OFF, STATUS_GOOD)});
        lamp_rows.push_back({cmd(MODE_TICK, 1, 0, 0), 1'b1,
                             lv(0, 0, 0, 0, PAT_OFF, STATUS_GOOD)});
        lamp_rows.push_back({cmd(MODE_PULSE, 0, 0, 1), 1'b0, t_lamp_levels'('0)});
        lamp_rows.push_back({cmd(MODE_TICK, 65535, 0, 0), 1'b1,
                             lv(0, 0, 0, 0, PAT_OFF, STATUS_GOOD)});
        lamp_rows.push_back({cmd(MODE_SET, 0, PAT_HEARTBEAT, 0), 1'b1,
                             lv(0, 0, 0, 0, PAT_HEARTBEAT, STATUS_GOOD)});
        lamp_rows.push_back({cmd(MODE_TICK, 49, 0, 0), 1'b1,
                             lv(1, 0, 0, 0, PAT_HEARTBEAT, STATUS_GOOD)});
        lamp_rows.push_back({cmd(MODE_TICK, 1, 0, 0), 1'b1,
                             lv(0, 0, 0, 0, PAT_HEARTBEAT, STATUS_GOOD)});
        lamp_rows.push_back({cmd(MODE_TICK, 4950, 0, 0), 1'b1,
                             lv(1, 0, 0, 0, PAT_HEARTBEAT, STATUS_GOOD)});
        lamp_rows.push_back({cmd(MODE_SET, 0, PAT_WATCH, 0), 1'b0, t_lamp_levels'('0)});
        lamp_rows.push_back({cmd(MODE_TICK, 499, 0, 0), 1'b0, t_lamp_levels'('0)});
        lamp_rows.push_back({cmd(MODE_TICK, 1, 0, 0), 1'b0, t_lamp_levels'('0)});
        lamp_rows.push_back({cmd(MODE_TICK, 9500, 0, 0), 1'b0, t_lamp_levels'('0)});
        lamp_rows.push_back({cmd(MODE_SET, 0, PAT_WARNING, 0), 1'b0, t_lamp_levels'('0)});
        lamp_rows.push_back({cmd(MODE_TICK, 59, 0, 0), 1'b0, t_lamp_levels'('0)});
        lamp_rows.push_back({cmd(MODE_TICK, 61, 0, 0), 1'b0, t_lamp_levels'('0)});
        lamp_rows.push_back({cmd(MODE_TICK, 60, 0, 0), 1'b0, t_lamp_levels'('0)});
        lamp_rows.push_back({cmd(MODE_SET, 0, PAT_STORM, 0), 1'b0, t_lamp_levels'('0)});
        lamp_rows.push_back({cmd(MODE_TICK, 100, 0, 0), 1'b0, t_lamp_levels'('0)});
        lamp_rows.push_back({cmd(MODE_PULSE, 0, 0, 1000), 1'b0, t_lamp_levels'('0)});
        // selecting pattern off also drops the relay
        lamp_rows.push_back({cmd(MODE_SET, 0, PAT_OFF, 0), 1'b1,
                             lv(0, 0, 0, 0, PAT_OFF, STATUS_GOOD)});
        lamp_rows.push_back({cmd(MODE_PULSE, 0, 0, 300), 1'b0, t_lamp_levels'('0)});
        lamp_rows.push_back({cmd(MODE_OFF, 0, 0, 0), 1'b1,
                             lv(0, 0, 0, 0, PAT_OFF, STATUS_GOOD)});
        lamp_rows.push_back({cmd(MODE_SET, 0, 6, 0), 1'b1,
                             lv(0, 0, 0, 0, PAT_OFF, STATUS_BAD_CODE)});

        foreach (lamp_rows[k]) begin
            row = lamp_rows[k];
            offer_cmd(row.cmd, row.typed, row.want);
        end

        // Zero limit leaves the relay on with nothing remaining
        limits[0] = 24'd0;
        limits[1] = 24'd1;
        limits[2] = 24'hFFFFFF;
        limits[3] = 24'd1000;
        limits[4] = 24'($urandom_range(2, 24'hFFFFFE));
        foreach (limits[p]) begin
            settle();
            write_limit(limits[p]);
            if (p == 1) hold_asks++;
            repeat (PHASE_ITEMS) offer_cmd(random_cmd(), 1'b0, '0);
        end

        // Full-rate stretch: no idling on either side
        settle();
        valid_idle_pct = 0;
        ready_idle_pct = 0;
        repeat (FULL_RATE_ITEMS) offer_cmd(random_cmd(), 1'b0, '0);
        valid_idle_pct = IDLE_PCT;
        ready_idle_pct = IDLE_PCT;

        settle();
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
